@@ sv/assert_macros.svh @@
// Assertion macros used by the top level of the ordered list block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define AST_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error(msg);

// Same-cycle implication.
`define AST_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define AST_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/olist_pkg.sv @@
// Types and codes shared by the ordered list controller, datapath and top level.
`timescale 1ns / 1ps

package olist_pkg;

    // action codes (input tuser[1:0])
    localparam logic [1:0] ACT_HEAD   = 2'd0;
    localparam logic [1:0] ACT_TAIL   = 2'd1;
    localparam logic [1:0] ACT_DELETE = 2'd2;

    // status codes (output tdata[1:0])
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    localparam int LENGTH_BITS = 5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_HEAD_SHIFT,
        S_HEAD_WR,
        S_SCAN,
        S_SHIFT_DN,
        S_FINISH
    } state_t;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_ZERO,
        PTR_TOP,
        PTR_INC,
        PTR_DEC
    } ptr_op_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_HEAD,
        WR_TAIL,
        WR_UP,
        WR_DOWN
    } wr_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_CLEAR,
        CNT_INC,
        CNT_DEC
    } cnt_op_t;

    typedef struct packed {
        ptr_op_t    ptr_op;
        wr_op_t     wr_op;
        cnt_op_t    cnt_op;
        logic       val_load;
        logic       out_load;
        logic [1:0] status;
    } cmd_t;

    typedef struct packed {
        logic cnt_zero;
        logic cnt_full;
        logic ptr_zero;
        logic ptr_last;
        logic match;
    } sts_t;

endpackage

@@ sv/olist_dp.sv @@
// Datapath of the ordered list: entry memory, count, scan pointer and result register.
`timescale 1ns / 1ps

module olist_dp #(
    parameter int DEPTH      = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  olist_pkg::cmd_t                 cmd,
    output olist_pkg::sts_t                 sts,
    input  logic [VALUE_BITS-1:0]           in_value,
    output logic [1:0]                      out_status,
    output logic [olist_pkg::LENGTH_BITS-1:0] out_length
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [VALUE_BITS-1:0] mem [DEPTH];

    logic [CW-1:0]         count_reg, count_next;
    logic [CW-1:0]         ptr_reg, ptr_next;
    logic [VALUE_BITS-1:0] val_reg;
    logic [VALUE_BITS-1:0] rdata_reg;
    logic [1:0]            out_status_reg;
    logic [olist_pkg::LENGTH_BITS-1:0] out_length_reg;

    logic [CW-1:0]         ptr_plus1, ptr_minus1;
    logic                  wr_en;
    logic [IW-1:0]         wr_idx;
    logic [VALUE_BITS-1:0] wr_data;

    assign ptr_plus1  = ptr_reg + CW'(1);
    assign ptr_minus1 = ptr_reg - CW'(1);

    always_comb begin
        ptr_next = ptr_reg;
        case (cmd.ptr_op)
            olist_pkg::PTR_ZERO: ptr_next = '0;
            olist_pkg::PTR_TOP:  ptr_next = count_reg - CW'(1);
            olist_pkg::PTR_INC:  ptr_next = ptr_plus1;
            olist_pkg::PTR_DEC:  ptr_next = ptr_minus1;
            default:             ptr_next = ptr_reg;
        endcase
    end

    always_comb begin
        count_next = count_reg;
        unique case (cmd.cnt_op)
            olist_pkg::CNT_HOLD:  count_next = count_reg;
            olist_pkg::CNT_CLEAR: count_next = '0;
            olist_pkg::CNT_INC:   count_next = count_reg + CW'(1);
            olist_pkg::CNT_DEC:   count_next = count_reg - CW'(1);
            default:              count_next = count_reg;
        endcase
    end

    // one write port: a new value at head or tail, or a moved entry
    always_comb begin
        wr_en   = 1'b1;
        wr_idx  = '0;
        wr_data = val_reg;
        case (cmd.wr_op)
            olist_pkg::WR_HEAD: wr_idx = '0;
            olist_pkg::WR_TAIL: wr_idx = count_reg[IW-1:0];
            olist_pkg::WR_UP: begin
                wr_idx  = ptr_plus1[IW-1:0];
                wr_data = rdata_reg;
            end
            olist_pkg::WR_DOWN: begin
                wr_idx  = ptr_minus1[IW-1:0];
                wr_data = rdata_reg;
            end
            default: wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_idx] <= wr_data;
        end
        rdata_reg <= mem[ptr_next[IW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            ptr_reg   <= '0;
        end else begin
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.val_load) begin
            val_reg <= in_value;
        end
        if (cmd.out_load) begin
            out_status_reg <= cmd.status;
            out_length_reg <= olist_pkg::LENGTH_BITS'(count_reg);
        end
    end

    assign sts.cnt_zero = (count_reg == '0);
    assign sts.cnt_full = (count_reg == CW'(DEPTH));
    assign sts.ptr_zero = (ptr_reg == '0);
    assign sts.ptr_last = (ptr_plus1 == count_reg);
    assign sts.match    = (rdata_reg == val_reg);

    assign out_status = out_status_reg;
    assign out_length = out_length_reg;

endmodule

@@ sv/olist_ctrl.sv @@
// Controller state machine of the ordered list: sequences loads, scans and shifts.
`timescale 1ns / 1ps

module olist_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [1:0]       in_action,
    input  logic             in_start,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  olist_pkg::sts_t  sts,
    output olist_pkg::cmd_t  cmd
);

    olist_pkg::state_t state_reg, state_next;
    logic [1:0]        action_reg, action_next;
    logic [1:0]        status_reg, status_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == olist_pkg::S_IDLE);
    assign m_tvalid = out_valid_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            olist_pkg::S_IDLE: begin
                if (s_tvalid) state_next = olist_pkg::S_DECODE;
            end
            olist_pkg::S_DECODE: begin
                case (action_reg)
                    olist_pkg::ACT_HEAD: begin
                        if (sts.cnt_full || sts.cnt_zero) state_next = olist_pkg::S_FINISH;
                        else                              state_next = olist_pkg::S_HEAD_SHIFT;
                    end
                    olist_pkg::ACT_DELETE: begin
                        if (sts.cnt_zero) state_next = olist_pkg::S_FINISH;
                        else              state_next = olist_pkg::S_SCAN;
                    end
                    default: state_next = olist_pkg::S_FINISH;
                endcase
            end
            olist_pkg::S_HEAD_SHIFT: begin
                if (sts.ptr_zero) state_next = olist_pkg::S_HEAD_WR;
            end
            olist_pkg::S_HEAD_WR: state_next = olist_pkg::S_FINISH;
            olist_pkg::S_SCAN: begin
                if (sts.ptr_last)   state_next = olist_pkg::S_FINISH;
                else if (sts.match) state_next = olist_pkg::S_SHIFT_DN;
            end
            olist_pkg::S_SHIFT_DN: begin
                if (sts.ptr_last) state_next = olist_pkg::S_FINISH;
            end
            olist_pkg::S_FINISH: begin
                if (out_free) state_next = olist_pkg::S_IDLE;
            end
            default: state_next = olist_pkg::S_IDLE;
        endcase
    end

    // commands and result status
    always_comb begin
        cmd          = '0;
        cmd.ptr_op   = olist_pkg::PTR_HOLD;
        cmd.wr_op    = olist_pkg::WR_NONE;
        cmd.cnt_op   = olist_pkg::CNT_HOLD;
        cmd.status   = status_reg;
        action_next  = action_reg;
        status_next  = status_reg;
        unique case (state_reg)
            olist_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    cmd.val_load = 1'b1;
                    action_next  = in_action;
                    if (in_start && (in_action == olist_pkg::ACT_HEAD ||
                                     in_action == olist_pkg::ACT_TAIL)) begin
                        cmd.cnt_op = olist_pkg::CNT_CLEAR;
                    end
                end
            end
            olist_pkg::S_DECODE: begin
                status_next = olist_pkg::ST_DONE;
                case (action_reg)
                    olist_pkg::ACT_HEAD: begin
                        if (sts.cnt_full) begin
                            status_next = olist_pkg::ST_FULL;
                        end else if (sts.cnt_zero) begin
                            cmd.wr_op  = olist_pkg::WR_HEAD;
                            cmd.cnt_op = olist_pkg::CNT_INC;
                        end else begin
                            cmd.ptr_op = olist_pkg::PTR_TOP;
                        end
                    end
                    olist_pkg::ACT_TAIL: begin
                        if (sts.cnt_full) begin
                            status_next = olist_pkg::ST_FULL;
                        end else begin
                            cmd.wr_op  = olist_pkg::WR_TAIL;
                            cmd.cnt_op = olist_pkg::CNT_INC;
                        end
                    end
                    olist_pkg::ACT_DELETE: begin
                        if (sts.cnt_zero) status_next = olist_pkg::ST_EMPTY;
                        else              cmd.ptr_op  = olist_pkg::PTR_ZERO;
                    end
                    default: status_next = olist_pkg::ST_DONE;
                endcase
            end
            olist_pkg::S_HEAD_SHIFT: begin
                cmd.wr_op = olist_pkg::WR_UP;
                if (!sts.ptr_zero) cmd.ptr_op = olist_pkg::PTR_DEC;
            end
            olist_pkg::S_HEAD_WR: begin
                cmd.wr_op  = olist_pkg::WR_HEAD;
                cmd.cnt_op = olist_pkg::CNT_INC;
            end
            olist_pkg::S_SCAN: begin
                if (sts.match) begin
                    if (sts.ptr_last) cmd.cnt_op = olist_pkg::CNT_DEC;
                    else              cmd.ptr_op = olist_pkg::PTR_INC;
                end else if (sts.ptr_last) begin
                    status_next = olist_pkg::ST_NOT_FOUND;
                end else begin
                    cmd.ptr_op = olist_pkg::PTR_INC;
                end
            end
            olist_pkg::S_SHIFT_DN: begin
                cmd.wr_op = olist_pkg::WR_DOWN;
                if (sts.ptr_last) cmd.cnt_op = olist_pkg::CNT_DEC;
                else              cmd.ptr_op = olist_pkg::PTR_INC;
            end
            olist_pkg::S_FINISH: begin
                cmd.out_load = out_free;
            end
            default: cmd.out_load = 1'b0;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)  out_valid_next = 1'b1;
        else if (m_tready) out_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= olist_pkg::S_IDLE;
            action_reg    <= olist_pkg::ACT_HEAD;
            status_reg    <= olist_pkg::ST_DONE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            action_reg    <= action_next;
            status_reg    <= status_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ sv/ordered_list_delete_first_match.sv @@
// Top level of the bounded ordered list with front load, back load and first-match delete.
//
// Ordered list of up to DEPTH values, head first, kept in an entry memory
// with one write port and one read port, and a length count. One input
// beat carries one action and gives exactly one result beat (status, new
// length). A back load, a dropped load into a full list and a front load
// into an empty list go from decode straight to the result; any other
// front load first moves every entry up one place, and a delete compares
// entries up to the first match, then moves the rest down, one entry at a
// time through the memory port. The block takes one item at a time; the
// input is ready again once the result is in the output register, so a
// new item is accepted while that result beat still waits. A start mark
// on a load empties the list first, and the new length is reported modulo 32.
`timescale 1ns / 1ps

module ordered_list_delete_first_match #(
    parameter int DEPTH      = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value (signed)
    input  logic [2:0]  s_tuser,   // [1:0] action, [2] start_req
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [1:0] status, [6:2] length, [7] zero
);

    `include "assert_macros.svh"

    olist_pkg::cmd_t cmd;
    olist_pkg::sts_t sts;

    logic [VALUE_BITS-1:0]                 in_value;
    logic [1:0]                            out_status;
    logic [olist_pkg::LENGTH_BITS-1:0]     out_length;

    // only the low VALUE_BITS bits of a value are stored and compared
    assign in_value = VALUE_BITS'(s_tdata);

    olist_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .in_action (s_tuser[1:0]),
        .in_start  (s_tuser[2]),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    olist_dp #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .in_value   (in_value),
        .out_status (out_status),
        .out_length (out_length)
    );

    assign m_tdata = {1'b0, out_length, out_status};

    // count never runs past full or below empty
    `AST_ALWAYS(a_no_inc_full, !(cmd.cnt_op == olist_pkg::CNT_INC && sts.cnt_full), "count incremented while full")
    `AST_IMPL(a_no_dec_empty, cmd.cnt_op == olist_pkg::CNT_DEC, !sts.cnt_zero, "count decremented while empty")
    // a result is loaded only into a free output register
    `AST_IMPL(a_out_free, cmd.out_load, !m_tvalid || m_tready, "result overwrote a pending beat")
    // one item at a time
    `AST_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "input accepted while item in flight")

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the bounded ordered list with first-match delete.
`timescale 1ns / 1ps

module tb;

    localparam int          LIST_DEPTH  = 16;
    localparam logic [1:0]  ACT_UNUSED  = 2'd3;

    // Holds the expected list contents and the results still owed by the block.
    class list_scoreboard;
        bit [31:0] model_list[$];   // head at index 0
        bit [6:0]  owed[$];         // {length, status}
        int        mismatches;
        int        checked;
        int        status_count[4];
        int        start_loads;
        int        deepest;

        function int pending();
            return owed.size();
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            $display("%0t: mismatch: %s", $time, msg);
        endtask

        // Apply one accepted beat to the list copy and queue the result it owes.
        function void note_input(bit [31:0] value, bit [2:0] user);
            bit [1:0] action;
            bit       start;
            bit [1:0] status;
            bit [4:0] len;
            int       pos;
            action = user[1:0];
            start  = user[2];
            status = olist_pkg::ST_DONE;
            pos    = -1;
            if (action == olist_pkg::ACT_HEAD || action == olist_pkg::ACT_TAIL) begin
                if (start) begin
                    model_list.delete();
                    start_loads++;
                end
                if (model_list.size() >= LIST_DEPTH) begin
                    status = olist_pkg::ST_FULL;
                end else if (action == olist_pkg::ACT_HEAD) begin
                    model_list.push_front(value);
                end else begin
                    model_list.push_back(value);
                end
            end else if (action == olist_pkg::ACT_DELETE) begin
                if (model_list.size() == 0) begin
                    status = olist_pkg::ST_EMPTY;
                end else begin
                    foreach (model_list[i]) begin
                        if (pos < 0 && model_list[i] == value) pos = i;
                    end
                    if (pos < 0) status = olist_pkg::ST_NOT_FOUND;
                    else model_list.delete(pos);
                end
            end
            len = 5'(model_list.size());
            if (model_list.size() > deepest) deepest = model_list.size();
            owed.push_back({len, status});
        endfunction

        task check_result(logic [7:0] beat);
            bit [6:0] want;
            if (owed.size() == 0) begin
                report_mismatch($sformatf("result beat %h with nothing owed", beat));
                return;
            end
            want = owed.pop_front();
            checked++;
            status_count[want[1:0]]++;
            if (beat[1:0] !== want[1:0]) begin
                report_mismatch($sformatf("status %0d, want %0d", beat[1:0], want[1:0]));
            end
            if (beat[6:2] !== want[6:2]) begin
                report_mismatch($sformatf("length %0d, want %0d", beat[6:2], want[6:2]));
            end
            if (beat[7] !== 1'b0) begin
                report_mismatch("pad bit of result beat not zero");
            end
        endtask
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [2:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;

    list_scoreboard sb;
    bit [31:0]      value_pool[8];
    bit             quiet_sender;
    int             ready_hold;
    int             ready_roll;

    ordered_list_delete_first_match #(
        .DEPTH      (LIST_DEPTH),
        .VALUE_BITS (32)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Both handshakes are sampled here so an accepted beat is noted before any result.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_input(s_tdata, s_tuser);
            if (m_tvalid && m_tready) sb.check_result(m_tdata);
        end
    end

    // Result-side backpressure: short toggles, long ready stretches, rare long stalls.
    always @(negedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            ready_roll = $urandom_range(99);
            if (ready_roll < 50) begin
                m_tready   <= 1'b1;
                ready_hold <= $urandom_range(3);
            end else if (ready_roll < 75) begin
                m_tready   <= 1'b0;
                ready_hold <= $urandom_range(2);
            end else if (ready_roll < 95) begin
                m_tready   <= 1'b1;
                ready_hold <= $urandom_range(80, 20);
            end else begin
                m_tready   <= 1'b0;
                ready_hold <= $urandom_range(60, 20);
            end
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (quiet_sender || roll < 60) return 0;
        if (roll < 90) return $urandom_range(3, 1);
        if (roll < 97) return $urandom_range(10, 4);
        return $urandom_range(60, 20);
    endfunction

    // Present one beat at the falling edge, hold it until taken, then maybe idle.
    task automatic send_item(logic [1:0] action, logic [31:0] value, logic start);
        int gap;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tuser  <= {start, action};
        forever begin
            @(posedge aclk);
            if (s_tready) break;
        end
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            s_tuser  <= 3'($urandom);
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic directed_items();
        send_item(olist_pkg::ACT_DELETE, 32'd5, 1'b1);         // delete on empty list
        send_item(ACT_UNUSED, 32'hdead_beef, 1'b0);            // unused code does nothing
        send_item(olist_pkg::ACT_HEAD, 32'h8000_0000, 1'b0);
        send_item(olist_pkg::ACT_TAIL, 32'h7fff_ffff, 1'b0);
        send_item(olist_pkg::ACT_HEAD, 32'hffff_ffff, 1'b0);
        send_item(olist_pkg::ACT_TAIL, 32'h0000_0000, 1'b0);
        send_item(olist_pkg::ACT_HEAD, 32'h7fff_ffff, 1'b0);   // duplicate value
        send_item(olist_pkg::ACT_DELETE, 32'h1234_5678, 1'b0); // no match
        send_item(olist_pkg::ACT_DELETE, 32'h7fff_ffff, 1'b0); // nearest of two matches
        send_item(olist_pkg::ACT_DELETE, 32'h7fff_ffff, 1'b1); // start mark ignored on delete
        send_item(ACT_UNUSED, 32'h0000_0000, 1'b1);
        for (int i = 0; i < LIST_DEPTH - 3; i++) begin
            send_item((i % 2) ? olist_pkg::ACT_HEAD : olist_pkg::ACT_TAIL, $urandom, 1'b0);
        end
        send_item(olist_pkg::ACT_HEAD, 32'h0000_0055, 1'b0);   // full: dropped
        send_item(olist_pkg::ACT_TAIL, 32'h0000_00aa, 1'b0);   // full: dropped
        send_item(olist_pkg::ACT_DELETE, 32'h0000_0000, 1'b0);
        send_item(olist_pkg::ACT_TAIL, 32'h5555_aaaa, 1'b0);
        send_item(olist_pkg::ACT_HEAD, 32'haaaa_5555, 1'b1);   // rebuild from a full list
        send_item(olist_pkg::ACT_DELETE, 32'haaaa_5555, 1'b0);
        send_item(olist_pkg::ACT_TAIL, 32'h0000_0001, 1'b1);   // start mark on empty list
    endtask

    task automatic random_items(int n_items);
        int         load_pct;
        int         roll;
        logic [1:0] action;
        logic [31:0] value;
        load_pct = 50;
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7fff_ffff;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hffff_ffff;
        value_pool[4] = 32'h0000_0001;
        for (int i = 0; i < n_items; i++) begin
            // new phase: growth or shrink bias, fresh pool values, maybe no idling
            if (i % 64 == 0) begin
                case ($urandom_range(2))
                    0: load_pct = 25;
                    1: load_pct = 50;
                    default: load_pct = 80;
                endcase
                for (int k = 5; k < 8; k++) value_pool[k] = $urandom;
                quiet_sender = ($urandom_range(3) == 0);
            end
            if (i == n_items / 2) drain_results();
            roll = $urandom_range(99);
            if (roll < 2) action = ACT_UNUSED;
            else if (roll < 2 + load_pct)
                action = $urandom_range(1) ? olist_pkg::ACT_HEAD : olist_pkg::ACT_TAIL;
            else action = olist_pkg::ACT_DELETE;
            // a small pool keeps duplicates and delete hits frequent
            if ($urandom_range(99) < 75) value = value_pool[$urandom_range(7)];
            else value = $urandom;
            send_item(action, value, $urandom_range(99) < 4);
        end
        quiet_sender = 1'b0;
    endtask

    initial begin
        sb           = new();
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        m_tready     = 1'b0;
        ready_hold   = 0;
        quiet_sender = 1'b0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        directed_items();
        drain_results();
        random_items(1920);
        drain_results();
        repeat (40) @(posedge aclk);

        $display("covered %0d results: %0d done, %0d not found, %0d empty, %0d full drops",
                 sb.checked, sb.status_count[olist_pkg::ST_DONE],
                 sb.status_count[olist_pkg::ST_NOT_FOUND],
                 sb.status_count[olist_pkg::ST_EMPTY], sb.status_count[olist_pkg::ST_FULL]);
        $display("%0d loads with start mark, deepest list %0d entries",
                 sb.start_loads, sb.deepest);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("ordered_list_delete_first_match test passed");
        end else begin
            $display("ordered_list_delete_first_match test failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d results outstanding", sb.pending());
        $display("ordered_list_delete_first_match test failed");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+sv
sv/olist_pkg.sv
sv/olist_dp.sv
sv/olist_ctrl.sv
sv/ordered_list_delete_first_match.sv
dv/tb.sv
